[design/cfm_pkg.sv]
// Shared types, constants and the prefix mask function of the CIDR first-match filter.
package cfm_pkg;

   localparam int ADDR_W = 32;
   localparam int IDX_W = 4;
   localparam int PREFIX_W = 6;
   localparam int RULE_SLOTS_DEF = 16;
   localparam int REACHABLE_SLOTS = 2 ** IDX_W;

   localparam logic [ADDR_W-1:0] MASK_ALL = '1;
   localparam logic [PREFIX_W-1:0] PREFIX_FULL = PREFIX_W'(ADDR_W);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CHECK = 1'b1;

   typedef struct packed {
      logic                valid;
      logic                op;
      logic [ADDR_W-1:0]   address;
      logic [IDX_W-1:0]    rule_index;
      logic [ADDR_W-1:0]   rule_network;
      logic [PREFIX_W-1:0] rule_prefix;
      logic                rule_action;
      logic                rule_enable;
      logic                hit;
      logic                allow;
      logic [IDX_W-1:0]    hit_index;
   } beat_type;

   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PREFIX_W-1:0] len);
      logic [ADDR_W-1:0] mask;
      if (len >= PREFIX_FULL) begin
         mask = MASK_ALL;
      end else begin
         mask = ~(MASK_ALL >> len);
      end
      return mask;
   endfunction

endpackage

[design/cfm_req_if.sv]
// Request channel interface of the CIDR first-match filter.
interface cfm_req_if;
   logic                             valid;
   logic                             ready;
   logic                             op;
   logic [cfm_pkg::ADDR_W-1:0]       address;
   logic [cfm_pkg::IDX_W-1:0]        rule_index;
   logic [cfm_pkg::ADDR_W-1:0]       rule_network;
   logic [cfm_pkg::PREFIX_W-1:0]     rule_prefix;
   logic                             rule_action;
   logic                             rule_enable;

   modport source (
      output valid, op, address, rule_index, rule_network, rule_prefix, rule_action,
             rule_enable,
      input  ready
   );

   modport sink (
      input  valid, op, address, rule_index, rule_network, rule_prefix, rule_action,
             rule_enable,
      output ready
   );
endinterface

[design/cfm_rsp_if.sv]
// Response channel interface of the CIDR first-match filter.
interface cfm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         allow;
   logic                         hit;
   logic [cfm_pkg::IDX_W-1:0]    hit_index;

   modport source (
      output valid, allow, hit, hit_index,
      input  ready
   );

   modport sink (
      input  valid, allow, hit, hit_index,
      output ready
   );
endinterface

[design/cfm_cell.sv]
// One rule cell of the filter chain: holds a rule and passes each beat to its neighbor.
module cfm_cell #(
   parameter int INDEX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  cfm_pkg::beat_type beat_in,
   output cfm_pkg::beat_type beat_out
);

   cfm_pkg::beat_type beat_ff, beat_next_in;
   logic [cfm_pkg::ADDR_W-1:0] net_ff, net_in;
   logic [cfm_pkg::ADDR_W-1:0] mask_ff, mask_in;
   logic action_ff, action_in;
   logic rule_valid_ff, rule_valid_in;
   logic slot_sel;
   logic rule_match;
   logic [cfm_pkg::ADDR_W-1:0] new_mask;

   always_comb begin
      slot_sel = (INDEX < cfm_pkg::REACHABLE_SLOTS) &&
                 (beat_in.rule_index == cfm_pkg::IDX_W'(INDEX));
      new_mask = cfm_pkg::prefix_mask(beat_in.rule_prefix);
      rule_match = rule_valid_ff && ((beat_in.address & mask_ff) == net_ff);

      net_in = net_ff;
      mask_in = mask_ff;
      action_in = action_ff;
      rule_valid_in = rule_valid_ff;
      beat_next_in = beat_in;

      if (advance && beat_in.valid) begin
         if (beat_in.op == cfm_pkg::OP_WRITE) begin
            if (slot_sel) begin
               rule_valid_in = beat_in.rule_enable;
               if (beat_in.rule_enable) begin
                  net_in = beat_in.rule_network & new_mask;
                  mask_in = new_mask;
                  action_in = beat_in.rule_action;
               end
            end
         end else if (!beat_in.hit && rule_match) begin
            beat_next_in.hit = 1'b1;
            beat_next_in.allow = action_ff;
            beat_next_in.hit_index = cfm_pkg::IDX_W'(INDEX);
         end
      end
   end

   always_ff @(posedge clock) begin
      net_ff <= net_in;
      mask_ff <= mask_in;
      action_ff <= action_in;
      if (reset) begin
         rule_valid_ff <= 1'b0;
         beat_ff.valid <= 1'b0;
      end else begin
         rule_valid_ff <= rule_valid_in;
         if (advance) begin
            beat_ff <= beat_next_in;
         end
      end
   end

   assign beat_out = beat_ff;

`ifndef SYNTHESIS
   a_reset_clears_rule : assert property (@(posedge clock)
      reset |=> !rule_valid_ff)
      else $error("rule valid bit survived reset");

   a_earlier_hit_kept : assert property (@(posedge clock) disable iff (reset)
      advance && beat_in.valid && beat_in.hit |=>
         beat_ff.hit && beat_ff.hit_index == $past(beat_in.hit_index))
      else $error("earlier rule hit was overridden");

   a_hit_not_above_cell : assert property (@(posedge clock) disable iff (reset)
      beat_ff.valid && beat_ff.hit |-> int'(beat_ff.hit_index) <= INDEX)
      else $error("hit index beyond cell position");
`endif

endmodule

[design/cidr_first_match_filter_core.sv]
// Top level of the CIDR first-match filter: a chain of rule cells and a response register.
//
// Usage: the request channel carries rule writes (op low) and address checks
// (op high). A write stores or removes the rule at rule_index and gives no
// response beat. A check gives one response beat: allow, hit and hit_index of
// the lowest-index valid rule whose prefix covers the address, or deny with
// hit low and hit_index zero when no rule matches.
// Each request beat walks a chain of RULE_SLOTS cells, one cell per cycle while
// the chain advances, and a check then passes the response register before it
// appears on the response channel. One beat is accepted per cycle unless the
// chain holds; every later beat sees every earlier write in request order.
// Reset clears all rule valid bits and empties the chain; the rule contents
// themselves are not cleared. When the receiver stalls with a response beat
// waiting, the whole chain holds and req ready drops until that beat is taken.
module cidr_first_match_filter_core #(
   parameter int RULE_SLOTS = cfm_pkg::RULE_SLOTS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   cfm_req_if.sink   req_chan,
   cfm_rsp_if.source rsp_chan
);

   cfm_pkg::beat_type chain [RULE_SLOTS+1];
   logic advance;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_allow_ff, rsp_allow_in;
   logic rsp_hit_ff, rsp_hit_in;
   logic [cfm_pkg::IDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic last_check;

   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   always_comb begin
      chain[0].valid = req_chan.valid;
      chain[0].op = req_chan.op;
      chain[0].address = req_chan.address;
      chain[0].rule_index = req_chan.rule_index;
      chain[0].rule_network = req_chan.rule_network;
      chain[0].rule_prefix = req_chan.rule_prefix;
      chain[0].rule_action = req_chan.rule_action;
      chain[0].rule_enable = req_chan.rule_enable;
      chain[0].hit = 1'b0;
      chain[0].allow = 1'b0;
      chain[0].hit_index = '0;
   end

   for (genvar k = 0; k < RULE_SLOTS; k++) begin : g_cell
      cfm_cell #(
         .INDEX (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .beat_in  (chain[k]),
         .beat_out (chain[k+1])
      );
   end

   always_comb begin
      last_check = chain[RULE_SLOTS].valid && (chain[RULE_SLOTS].op == cfm_pkg::OP_CHECK);
      rsp_valid_in = rsp_valid_ff;
      rsp_allow_in = rsp_allow_ff;
      rsp_hit_in = rsp_hit_ff;
      rsp_index_in = rsp_index_ff;
      if (advance) begin
         rsp_valid_in = last_check;
         rsp_allow_in = chain[RULE_SLOTS].allow;
         rsp_hit_in = chain[RULE_SLOTS].hit;
         rsp_index_in = chain[RULE_SLOTS].hit_index;
      end
   end

   always_ff @(posedge clock) begin
      rsp_allow_ff <= rsp_allow_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_index_ff <= rsp_index_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.allow = rsp_allow_ff;
   assign rsp_chan.hit = rsp_hit_ff;
   assign rsp_chan.hit_index = rsp_index_ff;

`ifndef SYNTHESIS
   a_reset_empties_output : assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response beat survived reset");

   a_miss_is_deny : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_hit_ff |-> !rsp_allow_ff && rsp_index_ff == '0)
      else $error("miss response is not a clean deny");

   a_write_gives_no_beat : assert property (@(posedge clock) disable iff (reset)
      advance && chain[RULE_SLOTS].valid && chain[RULE_SLOTS].op == cfm_pkg::OP_WRITE
         |=> !rsp_valid_ff)
      else $error("write produced a response beat");
`endif

endmodule

[bench/cfm_verdict_checker.sv]
// Checker for the CIDR first-match filter: predicts each verdict and compares response beats.
`timescale 1ns / 100ps
module cfm_verdict_checker #(
   parameter int RULE_SLOTS = cfm_pkg::RULE_SLOTS_DEF
) (
   input  logic clock,
   input  logic reset,
   cfm_req_if   req_mon,
   cfm_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   verdicts_pending,
   output int   writes_seen,
   output int   checks_seen,
   output int   hits_seen
);

   typedef struct packed {
      logic                      allow;
      logic                      hit;
      logic [cfm_pkg::IDX_W-1:0] hit_index;
   } verdict_type;

   logic [cfm_pkg::ADDR_W-1:0]   rule_net   [RULE_SLOTS];
   logic [cfm_pkg::PREFIX_W-1:0] rule_len   [RULE_SLOTS];
   logic                         rule_allow [RULE_SLOTS];
   logic                         rule_live  [RULE_SLOTS];
   verdict_type                  verdict_q  [$];
   int                           bad_beats;
   int                           n_writes;
   int                           n_checks;
   int                           n_hits;

   // Scanning from the top slot down leaves the lowest-index match as the verdict.
   function automatic verdict_type lookup_verdict(input logic [cfm_pkg::ADDR_W-1:0] addr);
      verdict_type                found;
      logic [cfm_pkg::ADDR_W-1:0] keep;
      found = '0;
      for (int k = RULE_SLOTS - 1; k >= 0; k--) begin
         keep = (rule_len[k] == '0) ? '0 :
                cfm_pkg::MASK_ALL << (cfm_pkg::ADDR_W - int'(rule_len[k]));
         if (rule_live[k] && ((addr ^ rule_net[k]) & keep) == '0) begin
            found.allow = rule_allow[k];
            found.hit = 1'b1;
            found.hit_index = cfm_pkg::IDX_W'(k);
         end
      end
      return found;
   endfunction

   task automatic flag_beat(input string msg);
      bad_beats++;
      if (bad_beats <= 10) begin
         $display("ERROR at %0t: %s", $time, msg);
      end
   endtask

   always @(posedge clock) begin
      verdict_type got;
      verdict_type want;
      if (reset) begin
         for (int k = 0; k < RULE_SLOTS; k++) begin
            rule_live[k] = 1'b0;
         end
         verdict_q.delete();
         bad_beats = 0;
         n_writes = 0;
         n_checks = 0;
         n_hits = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.allow, rsp_mon.hit, rsp_mon.hit_index};
            if (verdict_q.size() == 0) begin
               flag_beat($sformatf({"response beat with no check pending: ",
                                    "allow %0b hit %0b index %0d"},
                                   got.allow, got.hit, got.hit_index));
            end else begin
               want = verdict_q.pop_front();
               if (got.allow !== want.allow || got.hit !== want.hit ||
                   got.hit_index !== want.hit_index) begin
                  flag_beat($sformatf({"verdict expected allow %0b hit %0b index %0d, ",
                                       "got allow %0b hit %0b index %0d"},
                                      want.allow, want.hit, want.hit_index,
                                      got.allow, got.hit, got.hit_index));
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.op == cfm_pkg::OP_WRITE) begin
               n_writes++;
               if (int'(req_mon.rule_index) < RULE_SLOTS) begin
                  if (req_mon.rule_enable) begin
                     rule_net[req_mon.rule_index] = req_mon.rule_network;
                     rule_len[req_mon.rule_index] =
                        (req_mon.rule_prefix > cfm_pkg::PREFIX_FULL) ?
                        cfm_pkg::PREFIX_FULL : req_mon.rule_prefix;
                     rule_allow[req_mon.rule_index] = req_mon.rule_action;
                     rule_live[req_mon.rule_index] = 1'b1;
                  end else begin
                     rule_live[req_mon.rule_index] = 1'b0;
                  end
               end
            end else begin
               want = lookup_verdict(req_mon.address);
               verdict_q.push_back(want);
               n_checks++;
               if (want.hit) begin
                  n_hits++;
               end
            end
         end
      end
      mismatch_count <= bad_beats;
      verdicts_pending <= verdict_q.size();
      writes_seen <= n_writes;
      checks_seen <= n_checks;
      hits_seen <= n_hits;
   end

endmodule

[bench/tb_cidr_first_match_filter_core.sv]
// Testbench top of the CIDR first-match filter: clock, reset, stimulus, back pressure and verdict.
`timescale 1ns / 100ps
module tb_cidr_first_match_filter_core;

   localparam int RULE_SLOTS = cfm_pkg::RULE_SLOTS_DEF;
   localparam int LATENCY = RULE_SLOTS + 1;
   localparam int STALL_LIMIT = 5000;
   localparam int LONG_HOLD = 300;
   localparam int PHASE_ITEMS = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_req = 1'b0;
   int  idle_cycles = 0;

   int  mismatch_count;
   int  verdicts_pending;
   int  writes_seen;
   int  checks_seen;
   int  hits_seen;

   logic [cfm_pkg::ADDR_W-1:0]   shadow_net   [RULE_SLOTS];
   logic [cfm_pkg::PREFIX_W-1:0] shadow_len   [RULE_SLOTS];
   bit                           shadow_known [RULE_SLOTS];

   cfm_req_if req_chan ();
   cfm_rsp_if rsp_chan ();

   cidr_first_match_filter_core #(
      .RULE_SLOTS(RULE_SLOTS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   cfm_verdict_checker #(
      .RULE_SLOTS(RULE_SLOTS)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .req_mon(req_chan),
      .rsp_mon(rsp_chan),
      .mismatch_count(mismatch_count),
      .verdicts_pending(verdicts_pending),
      .writes_seen(writes_seen),
      .checks_seen(checks_seen),
      .hits_seen(hits_seen)
   );

   always #1 clock = ~clock;

   task automatic offer(input logic op, input logic [cfm_pkg::ADDR_W-1:0] addr,
                        input logic [cfm_pkg::IDX_W-1:0] slot,
                        input logic [cfm_pkg::ADDR_W-1:0] net,
                        input logic [cfm_pkg::PREFIX_W-1:0] len, input logic act,
                        input logic en);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op <= op;
      req_chan.address <= addr;
      req_chan.rule_index <= slot;
      req_chan.rule_network <= net;
      req_chan.rule_prefix <= len;
      req_chan.rule_action <= act;
      req_chan.rule_enable <= en;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
   endtask

   task automatic write_rule(input logic [cfm_pkg::IDX_W-1:0] slot,
                             input logic [cfm_pkg::ADDR_W-1:0] net,
                             input logic [cfm_pkg::PREFIX_W-1:0] len, input logic act,
                             input logic en);
      if (en) begin
         shadow_net[slot] = net;
         shadow_len[slot] = len;
         shadow_known[slot] = 1'b1;
      end
      offer(cfm_pkg::OP_WRITE, $urandom(), slot, net, len, act, en);
   endtask

   task automatic check_address(input logic [cfm_pkg::ADDR_W-1:0] addr);
      offer(cfm_pkg::OP_CHECK, addr, cfm_pkg::IDX_W'($urandom()), $urandom(),
            cfm_pkg::PREFIX_W'($urandom()), 1'($urandom()), 1'($urandom()));
   endtask

   // Most addresses fall inside a rule written earlier; some sit just outside its prefix.
   function automatic logic [cfm_pkg::ADDR_W-1:0] pick_address();
      int unsigned                slot;
      int unsigned                bits;
      logic [cfm_pkg::ADDR_W-1:0] host;
      logic [cfm_pkg::ADDR_W-1:0] addr;
      slot = $urandom_range(RULE_SLOTS - 1);
      if (!shadow_known[slot] || $urandom_range(99) >= 70) begin
         return $urandom();
      end
      bits = (shadow_len[slot] > cfm_pkg::PREFIX_FULL) ? cfm_pkg::ADDR_W : shadow_len[slot];
      host = {cfm_pkg::ADDR_W{1'b1}} >> bits;
      addr = (shadow_net[slot] & ~host) | ($urandom() & host);
      if (bits > 0 && $urandom_range(9) == 0) begin
         addr ^= cfm_pkg::ADDR_W'(1) << (cfm_pkg::ADDR_W - bits);
      end
      return addr;
   endfunction

   task automatic random_item();
      int unsigned                  slot;
      logic [cfm_pkg::ADDR_W-1:0]   net;
      logic [cfm_pkg::PREFIX_W-1:0] len;
      slot = $urandom_range(RULE_SLOTS - 1);
      if ($urandom_range(99) < 25) begin
         case ($urandom_range(9))
            0: begin
               len = cfm_pkg::PREFIX_W'($urandom_range(63));
            end
            1: begin
               len = '0;
            end
            2: begin
               len = cfm_pkg::PREFIX_FULL;
            end
            default: begin
               len = cfm_pkg::PREFIX_W'($urandom_range(31, 1));
            end
         endcase
         net = $urandom_range(1) ? pick_address() : cfm_pkg::ADDR_W'($urandom());
         write_rule(cfm_pkg::IDX_W'(slot), net, len, 1'($urandom()), $urandom_range(99) < 85);
      end else begin
         check_address(pick_address());
      end
   endtask

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            repeat (LONG_HOLD) begin
               rsp_chan.ready <= 1'b0;
               @(posedge clock);
            end
            hold_req = 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      for (int k = 0; k < RULE_SLOTS; k++) begin
         shadow_known[k] = 1'b0;
      end
      req_chan.valid <= 1'b0;
      req_chan.op <= cfm_pkg::OP_WRITE;
      req_chan.address <= '0;
      req_chan.rule_index <= '0;
      req_chan.rule_network <= '0;
      req_chan.rule_prefix <= '0;
      req_chan.rule_action <= 1'b0;
      req_chan.rule_enable <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // An empty table denies everything.
      check_address(32'h0000_0000);
      write_rule(4'd15, 32'h0000_0000, 6'd0, 1'b1, 1'b1);
      write_rule(4'd0, 32'hFFFF_FFFF, 6'd32, 1'b0, 1'b1);
      write_rule(4'd1, 32'hC0A8_0000, 6'd16, 1'b1, 1'b1);
      write_rule(4'd2, 32'h0A00_0000, 6'd8, 1'b0, 1'b1);
      // An oversized prefix turns the rule into an exact host match.
      write_rule(4'd3, 32'h1234_5678, 6'd63, 1'b1, 1'b1);
      write_rule(4'd5, 32'h8000_0000, 6'd1, 1'b0, 1'b1);
      write_rule(4'd7, 32'h2AAA_AAAA, 6'd31, 1'b0, 1'b1);
      check_address(32'hFFFF_FFFF);
      check_address(32'hFFFF_FFFE);
      check_address(32'hC0A8_1234);
      check_address(32'hC0A9_FFFF);
      check_address(32'h0A0B_0C0D);
      check_address(32'h1234_5678);
      check_address(32'h1234_5679);
      check_address(32'h7FFF_FFFF);
      check_address(32'h2AAA_AAAB);
      check_address(32'h2AAA_AAA9);
      // Removing a rule lets the next match through; the catch-all removed leaves default deny.
      write_rule(4'd1, $urandom(), 6'd16, 1'b0, 1'b0);
      check_address(32'hC0A8_1234);
      write_rule(4'd15, $urandom(), 6'd0, 1'b1, 1'b0);
      check_address(32'h0000_0001);
      write_rule(4'd1, 32'hC0A8_1234, 6'd33, 1'b1, 1'b1);
      check_address(32'hC0A8_1234);
      check_address(32'hC0A8_1235);

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1) ? 83 : (ph == 3) ? 17 : 0;
         recv_stall_pct = (ph == 2) ? 83 : (ph == 3) ? 17 : 0;
         repeat (PHASE_ITEMS) random_item();
      end

      // The receiver holds off while the sender keeps offering, so the chain fills up.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_req = 1'b1;
      repeat (60) random_item();

      req_chan.valid <= 1'b0;
      while (verdicts_pending != 0 || hold_req) begin
         @(posedge clock);
      end
      repeat (2 * LATENCY) @(posedge clock);

      $display("Summary: %0d rule writes and %0d address checks, %0d of which matched a rule.",
               writes_seen, checks_seen, hits_seen);
      $display("Traffic ran free, with sender gaps, receiver stalls, both, and a long hold-off.");
      if (verdicts_pending != 0) begin
         $display("ERROR: %0d expected response beats never arrived", verdicts_pending);
      end
      if (mismatch_count == 0 && verdicts_pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
